/* hdl/rsi_pkg.sv */
// rsi_pkg: shared constants and types for the ray/segment intersection pipeline
// no dependencies
`timescale 1ns / 1ps

package rsi_pkg;

    localparam int COORD_WIDTH_DEF = 24;

    typedef struct packed {
        logic valid;
        logic hit;
        logic neg_x;
        logic neg_y;
    } ctl_t;

endpackage

/* hdl/ray_segment_intersect.sv */
// ray_segment_intersect: top level, front stages, two scale units, output stage
// depends on rsi_pkg, rsi_front, rsi_scale
`timescale 1ns / 1ps

// Fully pipelined ray against segment test. A transaction is taken on every
// cycle that start is high; busy never rises. Each transaction gives exactly one
// result, presented for one cycle with done high, after it has passed four setup
// stages, a two stage split multiply, the restoring divider (one quotient bit per
// stage) and the output register. Results must be captured on the done cycle,
// they are not held.

module ray_segment_intersect #(
    parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] ray_x,
    input  logic signed [COORD_WIDTH-1:0] ray_y,
    input  logic signed [COORD_WIDTH-1:0] dir_x,
    input  logic signed [COORD_WIDTH-1:0] dir_y,
    input  logic signed [COORD_WIDTH-1:0] seg_ax,
    input  logic signed [COORD_WIDTH-1:0] seg_ay,
    input  logic signed [COORD_WIDTH-1:0] seg_bx,
    input  logic signed [COORD_WIDTH-1:0] seg_by,
    output logic                          done,
    output logic                          hit,
    output logic signed [COORD_WIDTH-1:0] cross_x,
    output logic signed [COORD_WIDTH-1:0] cross_y
);

    localparam int W   = COORD_WIDTH;
    localparam int MW  = 2 * W + 2;
    localparam int LAT = W + 2;

    rsi_pkg::ctl_t       f_ctl;
    logic [MW-1:0]       f_rn_mag, f_d_mag;
    logic [W-1:0]        f_dx_mag, f_dy_mag;
    logic signed [W-1:0] f_ox, f_oy;
    logic [W-1:0]        qx, qy;

    rsi_pkg::ctl_t       ctl_pipe_reg [0:LAT-1];
    logic signed [W-1:0] ox_pipe_reg  [0:LAT-1];
    logic signed [W-1:0] oy_pipe_reg  [0:LAT-1];

    logic                done_reg, hit_reg;
    logic signed [W-1:0] cross_x_reg, cross_y_reg;
    logic signed [W-1:0] cross_x_next, cross_y_next;

    rsi_front #(.COORD_WIDTH(W)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .ray_x    (ray_x),
        .ray_y    (ray_y),
        .dir_x    (dir_x),
        .dir_y    (dir_y),
        .seg_ax   (seg_ax),
        .seg_ay   (seg_ay),
        .seg_bx   (seg_bx),
        .seg_by   (seg_by),
        .ctl      (f_ctl),
        .rn_mag   (f_rn_mag),
        .d_mag    (f_d_mag),
        .dx_mag   (f_dx_mag),
        .dy_mag   (f_dy_mag),
        .ox       (f_ox),
        .oy       (f_oy)
    );

    rsi_scale #(.COORD_WIDTH(W)) u_scale_x (
        .clk     (clk),
        .num_mag (f_rn_mag),
        .v_mag   (f_dx_mag),
        .den_mag (f_d_mag),
        .quot    (qx)
    );

    rsi_scale #(.COORD_WIDTH(W)) u_scale_y (
        .clk     (clk),
        .num_mag (f_rn_mag),
        .v_mag   (f_dy_mag),
        .den_mag (f_d_mag),
        .quot    (qy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
                ctl_pipe_reg[i] <= '0;
            done_reg <= 1'b0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            ctl_pipe_reg[0] <= f_ctl;
            for (int i = 1; i < LAT; i++)
                ctl_pipe_reg[i] <= ctl_pipe_reg[i-1];
            done_reg <= ctl_pipe_reg[LAT-1].valid;
            hit_reg  <= ctl_pipe_reg[LAT-1].hit;
        end
    end

    always_ff @(posedge clk)
    begin
        ox_pipe_reg[0] <= f_ox;
        oy_pipe_reg[0] <= f_oy;
        for (int i = 1; i < LAT; i++)
        begin
            ox_pipe_reg[i] <= ox_pipe_reg[i-1];
            oy_pipe_reg[i] <= oy_pipe_reg[i-1];
        end
        cross_x_reg <= cross_x_next;
        cross_y_reg <= cross_y_next;
    end

    function automatic logic [W-1:0] place(input logic [W-1:0] org,
                                           input logic [W-1:0] q,
                                           input logic         neg);
        logic [W:0]   off;
        logic [W+1:0] sum;
        logic [W-1:0] res;
        off = neg ? -{1'b0, q} : {1'b0, q};
        sum = {org[W-1], org[W-1], org} + {off[W], off};
        if (sum[W+1:W-1] == '0 || sum[W+1:W-1] == '1)
            res = sum[W-1:0];
        else if (sum[W+1])
            res = {1'b1, {(W-1){1'b0}}};
        else
            res = {1'b0, {(W-1){1'b1}}};
        return res;
    endfunction

    always_comb
    begin
        if (ctl_pipe_reg[LAT-1].hit)
        begin
            cross_x_next = place(ox_pipe_reg[LAT-1], qx, ctl_pipe_reg[LAT-1].neg_x);
            cross_y_next = place(oy_pipe_reg[LAT-1], qy, ctl_pipe_reg[LAT-1].neg_y);
        end
        else
        begin
            cross_x_next = '0;
            cross_y_next = '0;
        end
    end

    assign busy    = 1'b0;
    assign done    = done_reg;
    assign hit     = hit_reg;
    assign cross_x = cross_x_reg;
    assign cross_y = cross_y_reg;

endmodule

/* hdl/rsi_front.sv */
// rsi_front: edge/offset setup, cross products, determinant and range tests
// depends on rsi_pkg (ctl_t)
`timescale 1ns / 1ps

module rsi_front #(
    parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [COORD_WIDTH-1:0] ray_x,
    input  logic signed [COORD_WIDTH-1:0] ray_y,
    input  logic signed [COORD_WIDTH-1:0] dir_x,
    input  logic signed [COORD_WIDTH-1:0] dir_y,
    input  logic signed [COORD_WIDTH-1:0] seg_ax,
    input  logic signed [COORD_WIDTH-1:0] seg_ay,
    input  logic signed [COORD_WIDTH-1:0] seg_bx,
    input  logic signed [COORD_WIDTH-1:0] seg_by,
    output rsi_pkg::ctl_t                 ctl,
    output logic [2*COORD_WIDTH+1:0]      rn_mag,
    output logic [2*COORD_WIDTH+1:0]      d_mag,
    output logic [COORD_WIDTH-1:0]        dx_mag,
    output logic [COORD_WIDTH-1:0]        dy_mag,
    output logic signed [COORD_WIDTH-1:0] ox,
    output logic signed [COORD_WIDTH-1:0] oy
);

    localparam int W  = COORD_WIDTH;
    localparam int EW = W + 1;
    localparam int PW = 2 * W + 2;
    localparam int DW = 2 * W + 3;

    // stage 1: differences
    logic                 v1_reg;
    logic signed [EW-1:0] ex_reg, ey_reg, fx_reg, fy_reg;
    logic signed [W-1:0]  ox1_reg, oy1_reg, dx1_reg, dy1_reg;

    // stage 2: products
    logic                 v2_reg;
    logic signed [PW-1:0] p_dxey_reg, p_dyex_reg, p_fyex_reg;
    logic signed [PW-1:0] p_fxey_reg, p_fydx_reg, p_fxdy_reg;
    logic signed [W-1:0]  ox2_reg, oy2_reg, dx2_reg, dy2_reg;

    // stage 3: determinant and numerators
    logic                 v3_reg;
    logic signed [DW-1:0] d_reg, rn_reg, sn_reg;
    logic signed [W-1:0]  ox3_reg, oy3_reg, dx3_reg, dy3_reg;

    // stage 4: tests and magnitudes
    rsi_pkg::ctl_t        ctl_reg, ctl_next;
    logic [PW-1:0]        rn_mag_reg, d_mag_reg;
    logic [W-1:0]         dx_mag_reg, dy_mag_reg;
    logic signed [W-1:0]  ox4_reg, oy4_reg;

    logic signed [DW-1:0] rn_neg, d_neg, dx_neg, dy_neg;
    logic                 r_ok, s_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            ctl_reg <= '0;
        end
        else
        begin
            v1_reg  <= in_valid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ex_reg  <= {seg_bx[W-1], seg_bx} - {seg_ax[W-1], seg_ax};
        ey_reg  <= {seg_by[W-1], seg_by} - {seg_ay[W-1], seg_ay};
        fx_reg  <= {ray_x[W-1], ray_x} - {seg_ax[W-1], seg_ax};
        fy_reg  <= {ray_y[W-1], ray_y} - {seg_ay[W-1], seg_ay};
        ox1_reg <= ray_x;
        oy1_reg <= ray_y;
        dx1_reg <= dir_x;
        dy1_reg <= dir_y;

        p_dxey_reg <= PW'(dx1_reg) * PW'(ey_reg);
        p_dyex_reg <= PW'(dy1_reg) * PW'(ex_reg);
        p_fyex_reg <= PW'(fy_reg) * PW'(ex_reg);
        p_fxey_reg <= PW'(fx_reg) * PW'(ey_reg);
        p_fydx_reg <= PW'(fy_reg) * PW'(dx1_reg);
        p_fxdy_reg <= PW'(fx_reg) * PW'(dy1_reg);
        ox2_reg <= ox1_reg;
        oy2_reg <= oy1_reg;
        dx2_reg <= dx1_reg;
        dy2_reg <= dy1_reg;

        d_reg  <= {p_dxey_reg[PW-1], p_dxey_reg} - {p_dyex_reg[PW-1], p_dyex_reg};
        rn_reg <= {p_fyex_reg[PW-1], p_fyex_reg} - {p_fxey_reg[PW-1], p_fxey_reg};
        sn_reg <= {p_fydx_reg[PW-1], p_fydx_reg} - {p_fxdy_reg[PW-1], p_fxdy_reg};
        ox3_reg <= ox2_reg;
        oy3_reg <= oy2_reg;
        dx3_reg <= dx2_reg;
        dy3_reg <= dy2_reg;

        rn_mag_reg <= rn_reg[DW-1] ? rn_neg[PW-1:0] : rn_reg[PW-1:0];
        d_mag_reg  <= d_reg[DW-1] ? d_neg[PW-1:0] : d_reg[PW-1:0];
        dx_mag_reg <= dx3_reg[W-1] ? dx_neg[W-1:0] : dx3_reg;
        dy_mag_reg <= dy3_reg[W-1] ? dy_neg[W-1:0] : dy3_reg;
        ox4_reg    <= ox3_reg;
        oy4_reg    <= oy3_reg;
    end

    always_comb
    begin
        rn_neg = -rn_reg;
        d_neg  = -d_reg;
        dx_neg = -DW'(dx3_reg);
        dy_neg = -DW'(dy3_reg);
        if (d_reg[DW-1])
        begin
            r_ok = (d_reg <= rn_reg) && (rn_reg <= 0);
            s_ok = (d_reg <= sn_reg) && (sn_reg <= 0);
        end
        else
        begin
            r_ok = (rn_reg >= 0) && (rn_reg <= d_reg);
            s_ok = (sn_reg >= 0) && (sn_reg <= d_reg);
        end
        ctl_next.valid = v3_reg;
        ctl_next.hit   = (d_reg != '0) && r_ok && s_ok;
        ctl_next.neg_x = rn_reg[DW-1] ^ dx3_reg[W-1] ^ d_reg[DW-1];
        ctl_next.neg_y = rn_reg[DW-1] ^ dy3_reg[W-1] ^ d_reg[DW-1];
    end

    assign ctl    = ctl_reg;
    assign rn_mag = rn_mag_reg;
    assign d_mag  = d_mag_reg;
    assign dx_mag = dx_mag_reg;
    assign dy_mag = dy_mag_reg;
    assign ox     = ox4_reg;
    assign oy     = oy4_reg;

endmodule

/* hdl/rsi_scale.sv */
// rsi_scale: unsigned trunc(rn * v / d), split multiply then one quotient bit per stage
// depends on rsi_pkg (parameter default only)
`timescale 1ns / 1ps

module rsi_scale #(
    parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic [2*COORD_WIDTH+1:0] num_mag,
    input  logic [COORD_WIDTH-1:0]   v_mag,
    input  logic [2*COORD_WIDTH+1:0] den_mag,
    output logic [COORD_WIDTH-1:0]   quot
);

    localparam int W  = COORD_WIDTH;
    localparam int H  = W + 1;
    localparam int MW = 2 * W + 2;
    localparam int PP = 2 * W + 1;
    localparam int NW = 3 * W + 2;

    logic [PP-1:0] pp_lo_reg, pp_hi_reg;
    logic [MW-1:0] den_a_reg;
    logic [NW-1:0] num_sum;

    logic [MW-1:0] rem_reg [0:W];
    logic [W-1:0]  low_reg [0:W];
    logic [W-1:0]  q_reg   [0:W];
    logic [MW-1:0] den_reg [0:W];

    always_comb
    begin
        num_sum = (NW'(pp_hi_reg) << H) + NW'(pp_lo_reg);
    end

    always_ff @(posedge clk)
    begin
        pp_lo_reg  <= PP'(num_mag[H-1:0]) * PP'(v_mag);
        pp_hi_reg  <= PP'(num_mag[MW-1:H]) * PP'(v_mag);
        den_a_reg  <= den_mag;
        rem_reg[0] <= num_sum[NW-1:W];
        low_reg[0] <= num_sum[W-1:0];
        q_reg[0]   <= '0;
        den_reg[0] <= den_a_reg;
    end

    for (genvar k = 0; k < W; k++)
    begin : g_div
        logic [MW:0] trial;
        logic [MW:0] diff;
        logic        ge;

        always_comb
        begin
            trial = {rem_reg[k], low_reg[k][W-1-k]};
            diff  = trial - {1'b0, den_reg[k]};
            ge    = trial >= {1'b0, den_reg[k]};
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1] <= ge ? diff[MW-1:0] : trial[MW-1:0];
            low_reg[k+1] <= low_reg[k];
            den_reg[k+1] <= den_reg[k];
            if (W > 1)
                q_reg[k+1] <= {q_reg[k][W-2:0], ge};
            else
                q_reg[k+1] <= W'(ge);
        end
    end

    assign quot = q_reg[W];

endmodule

/* dv/tb_ray_segment_intersect.sv */
// tb_ray_segment_intersect: self-checking testbench for the ray/segment intersection block
// drives random and directed transactions, predicts hit and crossing point, checks each done
// depends on rsi_pkg and ray_segment_intersect
`timescale 1ns / 1ps

class crossing_scoreboard;
    bit        exp_hit[$];
    bit [23:0] exp_x[$];
    bit [23:0] exp_y[$];
    int        errors;

    function new();
        errors = 0;
    endfunction

    // exact ratio test of num/den against 0..1
    static function bit in_unit(logic signed [63:0] num, logic signed [63:0] den);
        if (den < 0)
            return (num >= den) && (num <= 0);
        return (num >= 0) && (num <= den);
    endfunction

    static function bit [23:0] clamp24(logic signed [127:0] v);
        if (v > 128'sd8388607)
            return 24'h7fffff;
        if (v < -128'sd8388608)
            return 24'h800000;
        return v[23:0];
    endfunction

    function void queue_result(bit h, bit [23:0] x, bit [23:0] y);
        exp_hit = {exp_hit, h};
        exp_x   = {exp_x, x};
        exp_y   = {exp_y, y};
    endfunction

    function void note_segment(logic signed [23:0] ox, logic signed [23:0] oy,
                               logic signed [23:0] dx, logic signed [23:0] dy,
                               logic signed [23:0] ax, logic signed [23:0] ay,
                               logic signed [23:0] bx, logic signed [23:0] by);
        logic signed [63:0]  ex, ey, fx, fy, det, rn, sn;
        logic signed [127:0] qx, qy;
        ex = 64'(bx) - 64'(ax);
        ey = 64'(by) - 64'(ay);
        fx = 64'(ox) - 64'(ax);
        fy = 64'(oy) - 64'(ay);
        det = 64'(dx) * ey - 64'(dy) * ex;
        rn = fy * ex - fx * ey;
        sn = fy * 64'(dx) - fx * 64'(dy);
        if (det == 0 || !in_unit(rn, det) || !in_unit(sn, det))
        begin
            queue_result(1'b0, 24'h0, 24'h0);
        end
        else
        begin
            // signed division truncates toward zero
            qx = (128'(rn) * 128'(dx)) / 128'(det);
            qy = (128'(rn) * 128'(dy)) / 128'(det);
            queue_result(1'b1, clamp24(128'(ox) + qx), clamp24(128'(oy) + qy));
        end
    endfunction

    function void check_crossing(bit h, bit [23:0] x, bit [23:0] y);
        bit        eh;
        bit [23:0] ex, ey;
        if (exp_hit.size() == 0)
        begin
            $error("result with no transaction pending");
            errors++;
            return;
        end
        eh = exp_hit.pop_front();
        ex = exp_x.pop_front();
        ey = exp_y.pop_front();
        if (h !== eh)
        begin
            $error("hit: expected %0d actual %0d", eh, h);
            errors++;
        end
        if (x !== ex)
        begin
            $error("cross_x: expected %h actual %h", ex, x);
            errors++;
        end
        if (y !== ey)
        begin
            $error("cross_y: expected %h actual %h", ey, y);
            errors++;
        end
    endfunction

    function int pending();
        return exp_hit.size();
    endfunction
endclass

module tb_ray_segment_intersect;
    localparam int CW = rsi_pkg::COORD_WIDTH_DEF;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy, done, hit;
    logic signed [CW-1:0] ray_x = '0, ray_y = '0, dir_x = '0, dir_y = '0;
    logic signed [CW-1:0] seg_ax = '0, seg_ay = '0, seg_bx = '0, seg_by = '0;
    logic signed [CW-1:0] cross_x, cross_y;

    crossing_scoreboard sb = new();
    int idle_pct = 0;

    ray_segment_intersect dut (.*);

    always #6 clk = ~clk;

    always @(posedge clk)
        if (rst_n && done)
            sb.check_crossing(hit, cross_x, cross_y);

    task automatic send_segment(logic signed [CW-1:0] ox, logic signed [CW-1:0] oy,
                                logic signed [CW-1:0] dx, logic signed [CW-1:0] dy,
                                logic signed [CW-1:0] ax, logic signed [CW-1:0] ay,
                                logic signed [CW-1:0] bx, logic signed [CW-1:0] by);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        ray_x <= ox; ray_y <= oy; dir_x <= dx; dir_y <= dy;
        seg_ax <= ax; seg_ay <= ay; seg_bx <= bx; seg_by <= by;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_segment(ox, oy, dx, dy, ax, ay, bx, by);
    endtask

    function automatic logic signed [CW-1:0] rand_coord(int mode);
        case (mode)
            0: return CW'($urandom);
            1: return CW'($signed($urandom_range(8192)) - 4096);
            default: return CW'($signed($urandom_range(2000000)) - 1000000);
        endcase
    endfunction

    task automatic send_random();
        logic signed [CW-1:0] ox, oy, dx, dy, ax, ay, bx, by;
        int m;
        m = $urandom_range(2);
        ox = rand_coord(m); oy = rand_coord(m);
        ax = rand_coord(m); ay = rand_coord(m);
        bx = rand_coord(m); by = rand_coord(m);
        if ($urandom_range(3) != 0)
        begin
            // aim the ray through a point on the segment, often reaching it
            dx = CW'((64'(ax) + 64'(bx)) / 2 - 64'(ox));
            dy = CW'((64'(ay) + 64'(by)) / 2 - 64'(oy));
            if ($urandom_range(1))
            begin
                dx = CW'(64'(dx) * 2);
                dy = CW'(64'(dy) * 2);
            end
        end
        else
        begin
            dx = rand_coord(m); dy = rand_coord(m);
        end
        if ($urandom_range(19) == 0)
        begin
            bx = ax; by = ay;
        end
        send_segment(ox, oy, dx, dy, ax, ay, bx, by);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    localparam logic signed [CW-1:0] MAXC = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] MINC = {1'b1, {(CW-1){1'b0}}};

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // plain cross at the midpoint
        send_segment(0, 0, 4096, 4096, 4096, 0, 0, 4096);
        // hit at an endpoint of the segment and at the ray end
        send_segment(0, 0, 4096, 0, 4096, 0, 4096, 4096);
        send_segment(0, 0, 8192, 0, 8192, -4096, 8192, 4096);
        // just beyond the ray end
        send_segment(0, 0, 4096, 0, 4097, -4096, 4097, 4096);
        // parallel, collinear, zero direction, zero-length segment
        send_segment(0, 0, 4096, 0, 0, 4096, 4096, 4096);
        send_segment(0, 0, 4096, 0, 100, 0, 200, 0);
        send_segment(0, 0, 0, 0, 4096, 0, 0, 4096);
        send_segment(0, 0, 4096, 4096, 100, 100, 100, 100);
        // behind the origin
        send_segment(0, 0, 4096, 0, -100, -10, -100, 10);
        // extreme coordinates, saturating crossing points
        send_segment(MAXC, MAXC, MAXC, MAXC, MAXC, MINC, MINC, MAXC);
        send_segment(MAXC, 0, MAXC, 0, MINC, MINC, MINC, MAXC);
        send_segment(MAXC, 0, MINC, 0, MAXC, MINC, MAXC, MAXC);
        send_segment(MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC);
        send_segment(MINC, MINC, MINC, MINC, MAXC, MINC, MINC, MAXC);
        send_segment(MINC, MAXC, MAXC, MINC, MINC, MINC, MAXC, MAXC);
        send_segment(-1, -1, -1, -1, -1, 0, 0, -1);
        send_segment(MAXC, MAXC, MINC, MINC, 0, MAXC, MAXC, 0);
        drain();
        idle_pct = 12;
        repeat (150) send_random();
        // hold off until the pipeline is empty
        drain();
        idle_pct = 61;
        repeat (150) send_random();
        idle_pct = 0;
        repeat (150) send_random();
        drain();
        repeat (CW + 20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_ray_segment_intersect: PASS");
        else
            $display("tb_ray_segment_intersect: FAIL");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb_ray_segment_intersect: FAIL");
        $finish;
    end
endmodule
